// File: sv/lpht_pkg.sv
package lpht_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_LOOKUP = 2'd1;
   localparam logic [1:0] MODE_DELETE = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [1:0] MARK_FREE = 2'd0;
   localparam logic [1:0] MARK_USED = 2'd1;
   localparam logic [1:0] MARK_GONE = 2'd2;

   localparam int KEY_WIDTH  = 32;
   localparam int SIZE_WIDTH = 7;
   localparam int POS_WIDTH  = 6;

   // One classified operation as it travels from the front end to the back end.
   typedef struct packed {
      logic [1:0]           mode;
      logic [KEY_WIDTH-1:0] key;
   } op_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [POS_WIDTH-1:0] position;
   } result_type;

endpackage

// File: sv/lpht_req_if.sv
interface lpht_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [lpht_pkg::KEY_WIDTH-1:0] key;

   modport source (output valid, output mode, output key, input ready);
   modport sink (input valid, input mode, input key, output ready);
endinterface

// File: sv/lpht_rsp_if.sv
interface lpht_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     status;
   logic [lpht_pkg::POS_WIDTH-1:0] position;

   modport source (output valid, output status, output position, input ready);
   modport sink (input valid, input status, input position, output ready);
endinterface

// File: sv/linear_probe_hash_table_core.sv
// Channel  Direction  Payload
// req      in         mode, key
// rsp      out        status, position
// csr      in         size_in_use (write only)
//
// The front end accepts each beat, forms its home slot one remainder bit at a
// time and then offers it to the two-entry queue, holding it while the queue is
// full; a clear skips the division and goes straight to the queue.
// The probe engine pulls an item off the queue, spends a read state and then a
// compare state on each probed slot and presents the result until it is taken;
// a clear walks all TABLE_DEPTH slots.
// Reset is synchronous; the probe engine then walks every slot and marks it
// free before it takes its first item. Keys stay undefined.
// Both halves stall independently; a held rsp beat stops only the back end.
module linear_probe_hash_table_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   lpht_req_if.sink                            req,
   lpht_rsp_if.source                          rsp,
   input  logic                                csr_write,
   input  logic [lpht_pkg::SIZE_WIDTH-1:0]     csr_wdata
);
   localparam int IDX_WIDTH = $clog2(TABLE_DEPTH);

   logic [lpht_pkg::SIZE_WIDTH-1:0] size_reg_ff;
   logic [IDX_WIDTH:0]              size_eff;
   logic                            push;
   lpht_pkg::op_type                push_op;
   logic [IDX_WIDTH-1:0]            push_home;
   logic                            full;
   logic                            pop;
   logic                            empty;
   lpht_pkg::op_type                head_op;
   logic [IDX_WIDTH-1:0]            head_home;
   lpht_pkg::op_type                push_home_word;
   lpht_pkg::op_type                head_home_word;

   // The size register holds the raw value; the effective size clamps it
   // into one to TABLE_DEPTH.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_reg_ff <= lpht_pkg::SIZE_WIDTH'(64);
      end else if (csr_write) begin
         size_reg_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (size_reg_ff == '0) begin
         size_eff = (IDX_WIDTH+1)'(1);
      end else if (32'(size_reg_ff) > TABLE_DEPTH) begin
         size_eff = (IDX_WIDTH+1)'(TABLE_DEPTH);
      end else begin
         size_eff = (IDX_WIDTH+1)'(size_reg_ff);
      end
   end

   lpht_front #(.IDX_WIDTH(IDX_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .size      (size_eff),
      .push      (push),
      .push_op   (push_op),
      .push_home (push_home),
      .full      (full)
   );

   // The home slot rides alongside each operation in a parallel queue.
   assign push_home_word = {push_op.mode, lpht_pkg::KEY_WIDTH'(push_home)};

   lpht_queue u_queue_op (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_home_word),
      .full      (),
      .pop       (pop),
      .empty     (),
      .pop_data  (head_home_word)
   );

   lpht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_op),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (head_op)
   );

   assign head_home = head_home_word.key[IDX_WIDTH-1:0];

   lpht_back #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_WIDTH(IDX_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .size      (size_eff),
      .empty     (empty),
      .head_op   (head_op),
      .head_home (head_home),
      .pop       (pop),
      .rsp       (rsp)
   );
endmodule

// File: sv/lpht_queue.sv
// Small two-entry queue between the front end and the probe engine.
module lpht_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpht_pkg::op_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output lpht_pkg::op_type pop_data
);
   lpht_pkg::op_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: sv/lpht_front.sv
// Front end: takes request beats and computes the home slot of each key other than a clear's.
// The remainder is formed one quotient bit per cycle against the active size.
module lpht_front #(
   parameter int IDX_WIDTH   = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   lpht_req_if.sink                      req,
   input  logic [IDX_WIDTH:0]            size,
   output logic                          push,
   output lpht_pkg::op_type              push_op,
   output logic [IDX_WIDTH-1:0]          push_home,
   input  logic                          full
);
   localparam int KW = lpht_pkg::KEY_WIDTH;
   localparam int CW = $clog2(KW + 1);

   logic                 busy_ff;
   logic                 busy_in;
   lpht_pkg::op_type     op_ff;
   lpht_pkg::op_type     op_in;
   logic [KW-1:0]        shift_ff;
   logic [KW-1:0]        shift_in;
   logic [IDX_WIDTH:0]   rem_ff;
   logic [IDX_WIDTH:0]   rem_in;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        count_in;
   logic                 done_ff;
   logic                 done_in;
   logic [IDX_WIDTH+1:0] trial;

   assign req.ready = !busy_ff && !done_ff;
   assign push      = done_ff;
   assign push_op   = op_ff;
   assign push_home = rem_ff[IDX_WIDTH-1:0];

   always_comb begin
      busy_in  = busy_ff;
      op_in    = op_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      done_in  = done_ff;
      trial    = {rem_ff, shift_ff[KW-1]} - {1'b0, size};
      if (req.valid && req.ready) begin
         op_in.mode = req.mode;
         op_in.key  = req.key;
         shift_in   = req.key;
         rem_in     = '0;
         count_in   = '0;
         if (req.mode == lpht_pkg::MODE_CLEAR) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         shift_in = {shift_ff[KW-2:0], 1'b0};
         if (trial[IDX_WIDTH+1]) begin
            rem_in = {rem_ff[IDX_WIDTH-1:0], shift_ff[KW-1]};
         end else begin
            rem_in = trial[IDX_WIDTH:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(KW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (done_ff && !full) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
   end
endmodule

// File: sv/lpht_back.sv
// Back end: walks the probe path slot by slot, reading then comparing each, and keeps the table.
// A clear, and the time after reset, walk every slot once to mark it free.
module lpht_back #(
   parameter int TABLE_DEPTH = 64,
   parameter int IDX_WIDTH   = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [IDX_WIDTH:0]   size,
   input  logic                 empty,
   input  lpht_pkg::op_type     head_op,
   input  logic [IDX_WIDTH-1:0] head_home,
   output logic                 pop,
   lpht_rsp_if.source           rsp
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] ST_WIPE  = 3'd5;

   localparam logic [IDX_WIDTH-1:0] LAST_SLOT = IDX_WIDTH'(TABLE_DEPTH - 1);

   logic [lpht_pkg::KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
   logic [1:0]                     mark_ff [TABLE_DEPTH];

   logic [2:0]                     state_ff;
   logic [2:0]                     state_in;
   lpht_pkg::op_type               op_ff;
   logic [IDX_WIDTH-1:0]           pos_ff;
   logic [IDX_WIDTH-1:0]           pos_in;
   logic [IDX_WIDTH:0]             steps_ff;
   logic [IDX_WIDTH:0]             steps_in;
   logic [lpht_pkg::KEY_WIDTH-1:0] rd_key_ff;
   logic [1:0]                     rd_mark_ff;
   lpht_pkg::result_type           res_ff;
   lpht_pkg::result_type           res_in;
   logic                           wr_key;
   logic                           wr_mark;
   logic [1:0]                     wr_mark_val;
   logic [IDX_WIDTH-1:0]           pos_next;
   logic                           last_step;

   assign rsp.valid    = (state_ff == ST_OUT);
   assign rsp.status   = res_ff.status;
   assign rsp.position = res_ff.position;
   assign pop          = (state_ff == ST_IDLE) && !empty;

   always_comb begin
      pos_next  = ({1'b0, pos_ff} + 1'b1 >= size) ? '0 : pos_ff + 1'b1;
      last_step = ({1'b0, steps_ff} + 1'b1 >= {1'b0, size});
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      steps_in    = steps_ff;
      res_in      = res_ff;
      wr_key      = 1'b0;
      wr_mark     = 1'b0;
      wr_mark_val = lpht_pkg::MARK_FREE;
      case (state_ff)
         ST_IDLE: begin
            if (!empty) begin
               steps_in = '0;
               if (head_op.mode == lpht_pkg::MODE_CLEAR) begin
                  pos_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  pos_in   = head_home;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff.mode == lpht_pkg::MODE_INSERT) begin
               if (rd_mark_ff != lpht_pkg::MARK_USED) begin
                  wr_key      = 1'b1;
                  wr_mark     = 1'b1;
                  wr_mark_val = lpht_pkg::MARK_USED;
                  res_in      = '{lpht_pkg::STATUS_OK, lpht_pkg::POS_WIDTH'(pos_ff)};
                  state_in    = ST_OUT;
               end else if (last_step) begin
                  res_in   = '{lpht_pkg::STATUS_FULL, '0};
                  state_in = ST_OUT;
               end
            end else begin
               if (rd_mark_ff == lpht_pkg::MARK_FREE) begin
                  res_in   = '{lpht_pkg::STATUS_MISSING, '0};
                  state_in = ST_OUT;
               end else if (rd_mark_ff == lpht_pkg::MARK_USED && rd_key_ff == op_ff.key) begin
                  res_in   = '{lpht_pkg::STATUS_OK, lpht_pkg::POS_WIDTH'(pos_ff)};
                  state_in = ST_OUT;
                  if (op_ff.mode == lpht_pkg::MODE_DELETE) begin
                     wr_mark     = 1'b1;
                     wr_mark_val = lpht_pkg::MARK_GONE;
                  end
               end else if (last_step) begin
                  res_in   = '{lpht_pkg::STATUS_MISSING, '0};
                  state_in = ST_OUT;
               end
            end
            if (state_in == ST_CHECK) begin
               pos_in   = pos_next;
               steps_in = steps_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_CLEAR: begin
            wr_mark     = 1'b1;
            wr_mark_val = lpht_pkg::MARK_FREE;
            if (pos_ff == LAST_SLOT) begin
               res_in   = '{lpht_pkg::STATUS_OK, '0};
               state_in = ST_OUT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_WIPE: begin
            wr_mark     = 1'b1;
            wr_mark_val = lpht_pkg::MARK_FREE;
            if (pos_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WIPE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_mark) begin
         mark_ff[pos_ff] <= wr_mark_val;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         op_ff <= head_op;
      end
      steps_ff   <= steps_in;
      res_ff     <= res_in;
      rd_key_ff  <= key_mem[pos_ff];
      rd_mark_ff <= mark_ff[pos_ff];
      if (wr_key) begin
         key_mem[pos_ff] <= op_ff.key;
      end
   end
endmodule

// File: sv/lpht_checker.sv
module lpht_core_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_status,
   input logic [5:0] rsp_position
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
      else $error("rsp beat dropped while stalled");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("illegal status");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'd0 |-> rsp_position == 6'd0)
      else $error("position not zero on failure");

   a_req_mode_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !$isunknown(req_mode))
      else $error("req beat with unknown mode");
endmodule

bind linear_probe_hash_table_core lpht_core_props u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_mode     (req.mode),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_status   (rsp.status),
   .rsp_position (rsp.position)
);

// File: tb/lpht_checker.sv
module lpht_checker #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   lpht_req_if                             req,
   lpht_rsp_if                             rsp,
   input  logic                            csr_write,
   input  logic [lpht_pkg::SIZE_WIDTH-1:0] csr_wdata,
   output int                              failures,
   output int                              pending
);
   logic [lpht_pkg::KEY_WIDTH-1:0]  shadow_key [TABLE_DEPTH];
   logic [1:0]                      shadow_mark [TABLE_DEPTH];
   logic [lpht_pkg::SIZE_WIDTH-1:0] shadow_size;
   lpht_pkg::result_type            awaited_results [$];

   // Works out the outcome of one operation and updates the shadow table.
   function automatic lpht_pkg::result_type apply_operation(logic [1:0] mode,
                                                            logic [lpht_pkg::KEY_WIDTH-1:0] key);
      int unsigned          span;
      int unsigned          slot;
      int unsigned          step;
      lpht_pkg::result_type outcome;
      span = (shadow_size == 0) ? 1 : ((shadow_size > TABLE_DEPTH) ? TABLE_DEPTH : shadow_size);
      outcome.status = lpht_pkg::STATUS_OK;
      outcome.position = '0;
      slot = key % span;
      case (mode)
         lpht_pkg::MODE_INSERT: begin
            outcome.status = lpht_pkg::STATUS_FULL;
            for (step = 0; step < span; step++) begin
               if (shadow_mark[slot] != lpht_pkg::MARK_USED) begin
                  shadow_key[slot] = key;
                  shadow_mark[slot] = lpht_pkg::MARK_USED;
                  outcome.status = lpht_pkg::STATUS_OK;
                  outcome.position = slot[lpht_pkg::POS_WIDTH-1:0];
                  break;
               end
               slot = (slot + 1 >= span) ? 0 : slot + 1;
            end
         end
         lpht_pkg::MODE_LOOKUP, lpht_pkg::MODE_DELETE: begin
            outcome.status = lpht_pkg::STATUS_MISSING;
            for (step = 0; step < span; step++) begin
               if (shadow_mark[slot] == lpht_pkg::MARK_FREE) break;
               if (shadow_mark[slot] == lpht_pkg::MARK_USED && shadow_key[slot] == key) begin
                  outcome.status = lpht_pkg::STATUS_OK;
                  outcome.position = slot[lpht_pkg::POS_WIDTH-1:0];
                  if (mode == lpht_pkg::MODE_DELETE) shadow_mark[slot] = lpht_pkg::MARK_GONE;
                  break;
               end
               slot = (slot + 1 >= span) ? 0 : slot + 1;
            end
         end
         default: begin
            for (int i = 0; i < TABLE_DEPTH; i++) shadow_mark[i] = lpht_pkg::MARK_FREE;
         end
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      lpht_pkg::result_type wanted;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) shadow_mark[i] = lpht_pkg::MARK_FREE;
         shadow_size = 7'd64;
         awaited_results.delete();
         failures = 0;
         pending = 0;
      end else begin
         if (csr_write) shadow_size = csr_wdata;
         if (req.valid && req.ready) awaited_results.push_back(apply_operation(req.mode, req.key));
         if (rsp.valid && rsp.ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected rsp beat: status %0d position %0d", rsp.status, rsp.position);
               failures++;
            end else begin
               wanted = awaited_results.pop_front();
               if (rsp.status !== wanted.status) begin
                  $error("status: expected %0d, actual %0d", wanted.status, rsp.status);
                  failures++;
               end
               if (rsp.position !== wanted.position) begin
                  $error("position: expected %0d, actual %0d", wanted.position, rsp.position);
                  failures++;
               end
            end
         end
         pending = awaited_results.size();
      end
   end
endmodule

// File: tb/tb.sv
module tb;
   // Slowest beat: home-slot division plus a read and a compare per probe
   // over the whole table, so the drain allowance covers more than one of those.
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT  = 950000;
   localparam int PHASE_ITEMS  = 66;

   logic                            clock;
   logic                            reset;
   logic                            csr_write;
   logic [lpht_pkg::SIZE_WIDTH-1:0] csr_wdata;
   int                              failures;
   int                              pending;
   int                              sender_idle_pct;
   int                              receiver_stall_pct;
   int                              cycle_count;
   int                              random_sent;
   logic [lpht_pkg::KEY_WIDTH-1:0]  key_pool [24];

   lpht_req_if req ();
   lpht_rsp_if rsp ();

   linear_probe_hash_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   lpht_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver refuses a beat with the current stall percentage.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // A hung block is caught here rather than by waiting for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("linear_probe_hash_table_core regression: fail");
         $finish;
      end
   end

   // Presents one beat and holds it until the block takes it. The valid line
   // is lowered only when a gap follows, so it never toggles within a step.
   task automatic send_op(logic [1:0] mode, logic [lpht_pkg::KEY_WIDTH-1:0] key);
      int gap;
      req.valid <= 1'b1;
      req.mode  <= mode;
      req.key   <= key;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Writes the size register once the block has gone quiet. The drain
   // allowance is needed because the back end may still be finishing a probe.
   task automatic set_size(logic [lpht_pkg::SIZE_WIDTH-1:0] value);
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Random phase: mostly keys from a small pool so that the table fills,
   // collides and gathers tombstones, with the odd wide key and clear.
   task automatic random_phase();
      int pick;
      logic [1:0] mode;
      logic [lpht_pkg::KEY_WIDTH-1:0] key;
      foreach (key_pool[i]) key_pool[i] = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
      repeat (PHASE_ITEMS) begin
         // The three idling regimes cover the first three phases, the next three and the last two.
         if (random_sent < 3 * PHASE_ITEMS) begin
            sender_idle_pct = 7;
            receiver_stall_pct = 73;
         end else if (random_sent < 6 * PHASE_ITEMS) begin
            sender_idle_pct = 73;
            receiver_stall_pct = 7;
         end else begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 40) mode = lpht_pkg::MODE_INSERT;
         else if (pick < 70) mode = lpht_pkg::MODE_LOOKUP;
         else if (pick < 97) mode = lpht_pkg::MODE_DELETE;
         else mode = lpht_pkg::MODE_CLEAR;
         key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(23)] : $urandom;
         send_op(mode, key);
         random_sent++;
      end
   endtask

   initial begin
      logic [lpht_pkg::SIZE_WIDTH-1:0] sizes [8];
      sizes = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd13, 7'd3, 7'd64};
      random_sent = 0;
      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.mode = lpht_pkg::MODE_INSERT;
      req.key = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset size: collisions, wrap at the top slot,
      // a lookup past a tombstone, reuse of a tombstone and a clear.
      send_op(lpht_pkg::MODE_INSERT, 32'd0);
      send_op(lpht_pkg::MODE_INSERT, 32'd64);
      send_op(lpht_pkg::MODE_INSERT, 32'hFFFF_FFFF);
      send_op(lpht_pkg::MODE_INSERT, 32'd63);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd64);
      send_op(lpht_pkg::MODE_DELETE, 32'd0);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd64);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd128);
      send_op(lpht_pkg::MODE_INSERT, 32'd128);
      send_op(lpht_pkg::MODE_DELETE, 32'd5);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd63);
      send_op(lpht_pkg::MODE_CLEAR, 32'hFFFF_FFFF);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd0);

      // A single slot: the table fills at once and a lookup walks it whole.
      set_size(7'd1);
      send_op(lpht_pkg::MODE_INSERT, 32'd7);
      send_op(lpht_pkg::MODE_INSERT, 32'd8);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd9);
      send_op(lpht_pkg::MODE_DELETE, 32'd7);
      send_op(lpht_pkg::MODE_INSERT, 32'd9);

      // Zero is treated as one slot and an oversized value as the full table.
      set_size(7'd0);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd9);
      set_size(7'd127);
      send_op(lpht_pkg::MODE_LOOKUP, 32'd9);
      send_op(lpht_pkg::MODE_INSERT, 32'h8000_003F);
      send_op(lpht_pkg::MODE_CLEAR, 32'd0);

      foreach (sizes[i]) begin
         set_size(sizes[i]);
         random_phase();
         // Between settings a clear sometimes empties the table first.
         if ($urandom_range(1) == 0) send_op(lpht_pkg::MODE_CLEAR, $urandom);
      end

      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("linear_probe_hash_table_core regression: pass");
      end else begin
         $display("linear_probe_hash_table_core regression: fail");
      end
      $finish;
   end
endmodule
